// ===== rtl/gct_pkg.sv =====
// Shared types, opcodes and constants for the generation catch-up tracker.
`timescale 1ns / 1ps
package gct_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int ID_W              = 32;
  localparam int GEN_W             = 32;
  localparam int COUNT_W           = 4;
  localparam int COUNT_MAX         = 15;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  localparam logic [1:0] OP_RELOAD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_MARK   = 2'd2;
  localparam logic [1:0] OP_FORGET = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] consumer_id;
  } gct_req_t;

  typedef struct packed {
    logic               answer;
    logic               table_full;
    logic [GEN_W-1:0]   current_generation;
    logic [COUNT_W-1:0] behind_count;
    logic [COUNT_W-1:0] tracked_count;
  } gct_rsp_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } gct_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rsp_free;
  } gct_sts_t;

endpackage

// ===== rtl/generation_catchup_tracker_top.sv =====
// Top level of the generation catch-up tracker.
`timescale 1ns / 1ps
// Tracks a global generation counter and a table of TABLE_ENTRIES consumer ids with the
// generation each last caught up to. Opcodes are reload (bump generation, saturating),
// query (is the id behind), mark (record catch-up, answer set for the first mark of a
// nonzero generation) and forget. Each request produces exactly one result carrying the
// generation, the behind count and the tracked count. After a request is accepted, the
// entry table, which sits in a memory with one read port, is scanned one entry per cycle;
// the read data is registered, the scan is then closed and the result is committed to the
// output register. The next request is taken only after the commit, so a new request is
// not accepted before the previous one has been committed. The commit waits while an
// earlier result is still held under stall in the output register; a finished result
// waits there while the next request is accepted. The table needs no clearing pass after
// reset.
module generation_catchup_tracker_top #(
  parameter int TABLE_ENTRIES = gct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  gct_pkg::gct_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output gct_pkg::gct_rsp_t rsp_data
);

  gct_pkg::gct_cmd_t cmd;
  gct_pkg::gct_sts_t sts;

  gct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== rtl/gct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gct_ctrl.sv =====
// Controller state machine: accept, scan the table, commit and present the result.
`timescale 1ns / 1ps
module gct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  gct_pkg::gct_sts_t sts,
  output gct_pkg::gct_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.rsp_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_SCAN)
    else $error("start did not enter scan");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.rsp_free && state == S_COMMIT)
    else $error("commit while result register busy");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.commit) |-> req_stall)
    else $error("request taken while busy");

endmodule

// ===== rtl/gct_datapath.sv =====
// Datapath: generation counters, entry table, scan evaluation and result register.
`timescale 1ns / 1ps
module gct_datapath #(
  parameter int TABLE_ENTRIES = gct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gct_pkg::gct_cmd_t cmd,
  output gct_pkg::gct_sts_t sts,
  input  gct_pkg::gct_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output gct_pkg::gct_rsp_t rsp_data
);

  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD = gct_pkg::ID_W + gct_pkg::GEN_W;

  logic [TABLE_ENTRIES-1:0]  valid;
  logic [gct_pkg::GEN_W-1:0] global_generation;
  logic [gct_pkg::GEN_W-1:0] serviced_generation;
  logic [CW-1:0]             tracked;

  logic [1:0]                op;
  logic [gct_pkg::ID_W-1:0]  id;
  logic                      id_nz;

  logic [CW-1:0]             rd_idx;
  logic                      ev_pend;
  logic [IW-1:0]             ev_idx;
  logic                      ev_vbit;

  logic                      match_found;
  logic [IW-1:0]             match_idx;
  logic                      match_behind;
  logic                      free_found;
  logic [IW-1:0]             free_idx;
  logic [CW-1:0]             behind_excl;

  logic                      issue;
  logic [WORD-1:0]           ram_rdata;
  logic [gct_pkg::ID_W-1:0]  ev_id;
  logic [gct_pkg::GEN_W-1:0] ev_gen;
  logic                      ev_hit;
  logic                      ev_behind;

  logic                      is_mark;
  logic                      mark_ok;
  logic                      forget_hit;
  logic [IW-1:0]             slot;
  logic [CW-1:0]             behind_new;
  logic [CW-1:0]             tracked_new;
  logic                      first_service;
  gct_pkg::gct_rsp_t         rsp_next;

  assign issue     = cmd.scan && (rd_idx != CW'(TABLE_ENTRIES));
  assign ev_id     = ram_rdata[WORD-1:gct_pkg::GEN_W];
  assign ev_gen    = ram_rdata[gct_pkg::GEN_W-1:0];
  assign ev_hit    = ev_vbit && id_nz && (ev_id == id);
  assign ev_behind = ev_vbit && (ev_gen < global_generation);

  assign sts.scan_done = (rd_idx == CW'(TABLE_ENTRIES)) && !ev_pend;
  assign sts.rsp_free  = !rsp_valid || !rsp_stall;

  assign is_mark       = (op == gct_pkg::OP_MARK) && id_nz;
  assign mark_ok       = is_mark && (match_found || free_found);
  assign forget_hit    = (op == gct_pkg::OP_FORGET) && match_found;
  assign slot          = match_found ? match_idx : free_idx;
  assign first_service = (global_generation != '0) &&
                         (serviced_generation < global_generation);

  always_comb begin
    if (mark_ok || forget_hit) begin
      behind_new = behind_excl;
    end else begin
      behind_new = behind_excl + CW'(match_behind);
    end
    tracked_new = tracked;
    if (mark_ok && !match_found) begin
      tracked_new = tracked + CW'(1);
    end else if (forget_hit) begin
      tracked_new = tracked - CW'(1);
    end
    rsp_next.answer = 1'b0;
    if (op == gct_pkg::OP_QUERY) begin
      rsp_next.answer = match_found && match_behind;
    end else if (op == gct_pkg::OP_MARK) begin
      rsp_next.answer = mark_ok && first_service;
    end
    rsp_next.table_full         = is_mark && !mark_ok;
    rsp_next.current_generation = global_generation;
    rsp_next.behind_count  = (32'(behind_new) > 32'(gct_pkg::COUNT_MAX)) ?
                             gct_pkg::COUNT_W'(gct_pkg::COUNT_MAX) :
                             gct_pkg::COUNT_W'(behind_new);
    rsp_next.tracked_count = (32'(tracked_new) > 32'(gct_pkg::COUNT_MAX)) ?
                             gct_pkg::COUNT_W'(gct_pkg::COUNT_MAX) :
                             gct_pkg::COUNT_W'(tracked_new);
  end

  gct_ram #(
    .WIDTH (WORD),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.commit && mark_ok),
    .waddr (slot),
    .wdata ({id, global_generation}),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid               <= '0;
      global_generation   <= '0;
      serviced_generation <= '0;
      tracked             <= '0;
      rsp_valid           <= 1'b0;
      rd_idx              <= '0;
      ev_pend             <= 1'b0;
      match_found         <= 1'b0;
      free_found          <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.start) begin
        op           <= req_data.opcode;
        id           <= req_data.consumer_id;
        id_nz        <= (req_data.consumer_id != '0);
        rd_idx       <= '0;
        ev_pend      <= 1'b0;
        match_found  <= 1'b0;
        match_behind <= 1'b0;
        free_found   <= 1'b0;
        behind_excl  <= '0;
        if ((req_data.opcode == gct_pkg::OP_RELOAD) &&
            (global_generation != gct_pkg::GEN_MAX)) begin
          global_generation <= global_generation + 1'b1;
        end
      end
      if (cmd.scan) begin
        ev_pend <= issue;
        if (issue) begin
          rd_idx  <= rd_idx + CW'(1);
          ev_idx  <= rd_idx[IW-1:0];
          ev_vbit <= valid[rd_idx[IW-1:0]];
        end
      end
      if (ev_pend) begin
        if (ev_hit) begin
          match_found  <= 1'b1;
          match_idx    <= ev_idx;
          match_behind <= ev_behind;
        end else if (ev_behind) begin
          behind_excl <= behind_excl + CW'(1);
        end
        if (!ev_vbit && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= ev_idx;
        end
      end
      if (cmd.commit) begin
        rsp_data  <= rsp_next;
        tracked   <= tracked_new;
        if (mark_ok) begin
          valid[slot] <= 1'b1;
          if (first_service) begin
            serviced_generation <= global_generation;
          end
        end else if (forget_hit) begin
          valid[match_idx] <= 1'b0;
        end
      end
    end
  end

  a_tracked_pop: assert property (@(posedge clk) disable iff (rst)
    32'(tracked) == 32'($countones(valid)))
    else $error("tracked count out of step with valid bits");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && rsp_next.table_full) |-> (valid == '1))
    else $error("table_full reported with a free entry");

  a_serviced_le_gen: assert property (@(posedge clk) disable iff (rst)
    serviced_generation <= global_generation)
    else $error("serviced generation ahead of current generation");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the generation catch-up tracker: driver, monitor and predictor.
`timescale 1ns / 1ps
module testbench;
  import gct_pkg::*;

  localparam int SLOTS          = TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 140;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  gct_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  gct_rsp_t rsp_data;

  gct_req_t req_backlog[$];
  gct_rsp_t awaited_rsp[$];
  bit       req_fire = 1'b0;
  int       src_idle_pct = 0;
  int       rsp_stall_pct = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  logic                 slot_valid[SLOTS];
  logic [ID_W-1:0]      slot_id[SLOTS];
  logic [GEN_W-1:0]     slot_gen[SLOTS];
  logic [GEN_W-1:0]     gen_now = '0;
  logic [GEN_W-1:0]     gen_serviced = '0;
  logic [COUNT_W-1:0]   behind_now = '0;
  logic [ID_W-1:0]      id_pool[POOL_SIZE];

  generation_catchup_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  function automatic logic [COUNT_W-1:0] sat_count(int n);
    return (n > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(n);
  endfunction

  function automatic void count_behind();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_gen[i] < gen_now) n++;
    behind_now = sat_count(n);
  endfunction

  function automatic int lookup_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic gct_rsp_t tracker_step(gct_req_t r);
    gct_rsp_t res;
    int       slot;
    int       n;
    res  = '0;
    slot = -1;
    case (r.opcode)
      OP_RELOAD: begin
        if (gen_now != GEN_MAX) gen_now = gen_now + 1'b1;
        count_behind();
      end
      OP_QUERY: begin
        if (r.consumer_id != '0) begin
          slot = lookup_slot(r.consumer_id);
          if (slot >= 0 && slot_gen[slot] < gen_now) res.answer = 1'b1;
        end
      end
      OP_MARK: begin
        if (r.consumer_id != '0) begin
          slot = lookup_slot(r.consumer_id);
          if (slot < 0)
            for (int i = SLOTS - 1; i >= 0; i--)
              if (!slot_valid[i]) slot = i;
          if (slot < 0) begin
            res.table_full = 1'b1;
          end else begin
            slot_valid[slot] = 1'b1;
            slot_id[slot]    = r.consumer_id;
            slot_gen[slot]   = gen_now;
            count_behind();
            if (gen_now != '0 && gen_serviced < gen_now) begin
              gen_serviced = gen_now;
              res.answer   = 1'b1;
            end
          end
        end
      end
      OP_FORGET: begin
        if (r.consumer_id != '0) begin
          slot = lookup_slot(r.consumer_id);
          if (slot >= 0) slot_valid[slot] = 1'b0;
        end
        count_behind();
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i]) n++;
    res.current_generation = gen_now;
    res.behind_count       = behind_now;
    res.tracked_count      = sat_count(n);
    return res;
  endfunction

  task automatic push_req(logic [1:0] op, logic [ID_W-1:0] id);
    gct_req_t r;
    r.opcode      = op;
    r.consumer_id = id;
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0);
  endtask

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req_valid <= 1'b1;
        req_data  <= req_backlog.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    gct_rsp_t want;
    req_fire = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        quiet_cycles = 0;
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: answer=%b full=%b gen=%h behind=%0d tracked=%0d",
                     rsp_data.answer, rsp_data.table_full, rsp_data.current_generation,
                     rsp_data.behind_count, rsp_data.tracked_count);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected answer=%b full=%b gen=%h behind=%0d tracked=%0d",
                       want.answer, want.table_full, want.current_generation,
                       want.behind_count, want.tracked_count);
              $display("          got      answer=%b full=%b gen=%h behind=%0d tracked=%0d",
                       rsp_data.answer, rsp_data.table_full, rsp_data.current_generation,
                       rsp_data.behind_count, rsp_data.tracked_count);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        req_fire     = 1'b1;
        quiet_cycles = 0;
        awaited_rsp.push_back(tracker_step(req_data));
      end
      if (!req_fire && !(rsp_valid && !rsp_stall)) quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int         idle_src[4];
    int         idle_rsp[4];
    int         pick;
    logic [1:0] op;
    logic [ID_W-1:0] id;
    idle_src = '{0, 60, 0, 24};
    idle_rsp = '{0, 0, 60, 24};
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_id[i]    = '0;
      slot_gen[i]   = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      do id = $urandom; while (id == '0);
      id_pool[i] = id;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_req(OP_QUERY, '0);
    push_req(OP_MARK, '0);
    push_req(OP_FORGET, '0);
    push_req(OP_MARK, '1);
    push_req(OP_QUERY, 32'h1234_5678);
    push_req(OP_RELOAD, '0);
    push_req(OP_QUERY, '1);
    push_req(OP_MARK, 32'd1);
    push_req(OP_MARK, 32'd2);
    for (int i = 3; i <= 7; i++) push_req(OP_MARK, ID_W'(i));
    push_req(OP_MARK, 32'd8);
    push_req(OP_FORGET, 32'd2);
    push_req(OP_MARK, 32'd8);
    push_req(OP_FORGET, 32'hDEAD_BEEF);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_src[p];
      rsp_stall_pct = idle_rsp[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 20)      op = OP_RELOAD;
        else if (pick < 50) op = OP_QUERY;
        else if (pick < 85) op = OP_MARK;
        else                op = OP_FORGET;
        pick = $urandom_range(99);
        if (pick < 5)       id = '0;
        else if (pick < 15) id = $urandom;
        else                id = id_pool[$urandom_range(POOL_SIZE - 1)];
        push_req(op, id);
      end
      wait_drained();
    end

    rsp_stall_pct = 0;
    repeat (30) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gct_pkg.sv
rtl/gct_ram.sv
rtl/gct_ctrl.sv
rtl/gct_datapath.sv
rtl/generation_catchup_tracker_top.sv
bench/testbench.sv
